@@ rtl/agent_collision_set_top_assert.svh @@
// ----------------------------------------------------------------------------
// agent_collision_set_top_assert.svh
// Assertion macros for the agent collision set check.
// ----------------------------------------------------------------------------
`ifndef AGENT_COLLISION_SET_TOP_ASSERT_SVH
`define AGENT_COLLISION_SET_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define ACS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after its trigger
`define ACS_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// acs_pkg
// Shared constants and types of the agent collision set check.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Sizing
  localparam int NUM_AGENTS = 16;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int MASK_W     = 16;
  localparam int IDX_W      = $clog2(NUM_AGENTS);
  localparam int CNT_W      = $clog2(NUM_AGENTS + 1);

  // Compare pass: inject up to NUM_AGENTS probes, then let them run down the chain
  localparam int PASS_LEN   = 2 * NUM_AGENTS + 1;
  localparam int PASS_W     = $clog2(PASS_LEN);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(PASS_LEN - 1);

  // One agent's cells, truncated to the compared coordinate bits
  typedef struct packed {
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [COORD_BITS-1:0] next_x;
    logic [COORD_BITS-1:0] next_y;
  } agent_t;

  // Agent travelling down the chain
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    agent_t           agent;
  } probe_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic clear;  // start of a compare pass: drop old hits
    logic load;   // store the incoming agent in this cell
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } acs_state_e;

endpackage

@@ rtl/agent_collision_set_top.sv @@
// Input: one agent per transfer cycle while loading; in_ready_o stays low during
// the compare pass that the agent marked last starts, so a new set waits until
// the pass ends. The pass walks every stored agent down the chain of slots.
// Reset: asynchronous, clears the agent count, overflow flag and handshakes.
// ----------------------------------------------------------------------------
// agent_collision_set_top
// Vertex and swap collision check over a set of agents, one slot per agent.
// ----------------------------------------------------------------------------
`include "agent_collision_set_top_assert.svh"

module agent_collision_set_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [acs_pkg::FIELD_W-1:0]   prev_x_i,
  input  logic [acs_pkg::FIELD_W-1:0]   prev_y_i,
  input  logic [acs_pkg::FIELD_W-1:0]   next_x_i,
  input  logic [acs_pkg::FIELD_W-1:0]   next_y_i,
  input  logic                          last_agent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acs_pkg::MASK_W-1:0]    conflict_mask_o,
  output logic                          overflow_o
);
  import acs_pkg::*;

  acs_state_e        state_q, state_d;
  logic [PASS_W-1:0] pass_cnt_q, pass_cnt_d;
  logic [CNT_W-1:0]  agent_cnt_q, agent_cnt_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [MASK_W-1:0] mask_q;
  logic              out_ovf_q;
  logic [MASK_W-1:0] mask_bits;
  logic              in_xfer;
  logic              finish;
  logic              inject;
  agent_t            in_agent;
  agent_t            cell_agent [NUM_AGENTS];
  probe_t            chain      [NUM_AGENTS+1];
  logic [NUM_AGENTS-1:0] cell_hit;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_RUN) && (pass_cnt_q == PASS_LAST) &&
                      (!out_valid_q || out_ready_i);

  assign in_agent.prev_x = COORD_BITS'(prev_x_i);
  assign in_agent.prev_y = COORD_BITS'(prev_y_i);
  assign in_agent.next_x = COORD_BITS'(next_x_i);
  assign in_agent.next_y = COORD_BITS'(next_y_i);

  // Probe injection at the head of the chain, one stored agent per cycle
  assign inject         = (state_q == ST_RUN) && (pass_cnt_q < PASS_W'(agent_cnt_q));
  assign chain[0].valid = inject;
  assign chain[0].idx   = pass_cnt_q[IDX_W-1:0];
  assign chain[0].agent = cell_agent[pass_cnt_q[IDX_W-1:0]];

  // Chain of agent slots
  for (genvar g = 0; g < NUM_AGENTS; g++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.clear = in_xfer && last_agent_i;
    assign ctrl.load  = in_xfer && (agent_cnt_q == CNT_W'(g));
    acs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(g)),
      .agent_i    (in_agent),
      .probe_i    (chain[g]),
      .probe_o    (chain[g+1]),
      .agent_o    (cell_agent[g]),
      .hit_o      (cell_hit[g])
    );
  end

  // Result mask: only slots holding an agent of this set count
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_AGENTS) begin : g_live
      assign mask_bits[b] = cell_hit[b] && (CNT_W'(b) < agent_cnt_q);
    end else begin : g_none
      assign mask_bits[b] = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pass_cnt_d  = pass_cnt_q;
    agent_cnt_d = agent_cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (agent_cnt_q < CNT_W'(NUM_AGENTS)) begin
            agent_cnt_d = agent_cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_agent_i) begin
            state_d    = ST_RUN;
            pass_cnt_d = '0;
          end
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d     = ST_LOAD;
          agent_cnt_d = '0;
          ovf_d       = 1'b0;
          out_valid_d = 1'b1;
        end else if (pass_cnt_q != PASS_LAST) begin
          pass_cnt_d = pass_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pass_cnt_q  <= '0;
      agent_cnt_q <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_cnt_q  <= pass_cnt_d;
      agent_cnt_q <= agent_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      mask_q    <= mask_bits;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign conflict_mask_o = mask_q;
  assign overflow_o      = out_ovf_q;

  // Checks
  `ACS_ASSERT(a_cnt_bound, agent_cnt_q <= CNT_W'(NUM_AGENTS), "agent count above slot count")
  `ACS_ASSERT_NEXT(a_last_starts_pass, in_xfer && last_agent_i,
    state_q == ST_RUN && pass_cnt_q == '0, "last agent did not start the compare pass")
  `ACS_ASSERT(a_result_from_pass, $rose(out_valid_q) |-> $past(state_q == ST_RUN),
    "result raised outside a compare pass")
  `ACS_ASSERT(a_cnt_stable_in_pass,
    (state_q == ST_RUN && $past(state_q == ST_RUN)) |-> $stable(agent_cnt_q),
    "agent count changed during the compare pass")

endmodule

@@ rtl/acs_cell.sv @@
// ----------------------------------------------------------------------------
// acs_cell
// One agent slot: holds the agent's cells, compares each passing probe
// against them and forwards the probe to the next slot.
// ----------------------------------------------------------------------------
module acs_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acs_pkg::cell_ctrl_t      ctrl_i,
  input  logic [acs_pkg::IDX_W-1:0] cell_idx_i,
  input  acs_pkg::agent_t          agent_i,
  input  acs_pkg::probe_t          probe_i,
  output acs_pkg::probe_t          probe_o,
  output acs_pkg::agent_t          agent_o,
  output logic                     hit_o
);
  import acs_pkg::*;

  agent_t agent_q;
  logic   probe_vld_q;
  logic [IDX_W-1:0] probe_idx_q;
  agent_t probe_agent_q;
  logic   vtx_hit_q, vtx_hit_d;
  logic   swp_hit_q, swp_hit_d;
  logic   swp_found_q, swp_found_d;
  logic   other_agent;
  logic   next_same;
  logic   prev_to_next;
  logic   back_to_prev;

  // Stored agent
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      agent_q <= agent_i;
    end
  end

  // Probe stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_vld_q <= 1'b0;
    end else begin
      probe_vld_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_idx_q   <= probe_i.idx;
    probe_agent_q <= probe_i.agent;
  end

  // Compares against the probe
  assign other_agent  = (probe_idx_q != cell_idx_i);
  assign next_same    = (probe_agent_q.next_x == agent_q.next_x) &&
                        (probe_agent_q.next_y == agent_q.next_y);
  assign prev_to_next = (probe_agent_q.prev_x == agent_q.next_x) &&
                        (probe_agent_q.prev_y == agent_q.next_y);
  assign back_to_prev = (probe_agent_q.next_x == agent_q.prev_x) &&
                        (probe_agent_q.next_y == agent_q.prev_y);

  // Hit accumulation; probes arrive in increasing agent order, so the first
  // probe whose previous cell is our next cell decides the swap case
  always_comb begin
    vtx_hit_d   = vtx_hit_q;
    swp_hit_d   = swp_hit_q;
    swp_found_d = swp_found_q;
    if (ctrl_i.clear) begin
      vtx_hit_d   = 1'b0;
      swp_hit_d   = 1'b0;
      swp_found_d = 1'b0;
    end else if (probe_vld_q) begin
      if (other_agent && next_same) begin
        vtx_hit_d = 1'b1;
      end
      if (!swp_found_q && prev_to_next) begin
        swp_found_d = 1'b1;
        if (other_agent && back_to_prev) begin
          swp_hit_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_hit_q   <= 1'b0;
      swp_hit_q   <= 1'b0;
      swp_found_q <= 1'b0;
    end else begin
      vtx_hit_q   <= vtx_hit_d;
      swp_hit_q   <= swp_hit_d;
      swp_found_q <= swp_found_d;
    end
  end

  assign probe_o.valid = probe_vld_q;
  assign probe_o.idx   = probe_idx_q;
  assign probe_o.agent = probe_agent_q;
  assign agent_o       = agent_q;
  assign hit_o         = vtx_hit_q | swp_hit_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sets of agents into agent_collision_set_top and checks each
// conflict mask and overflow flag against a cycle-free model of the vertex
// and swap collision rules, under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import acs_pkg::*;

  // Expected outcome of one agent set
  typedef struct {
    logic [MASK_W-1:0] mask;
    logic              ovf;
  } verdict_t;

  // Collects agents of the current set and predicts the mask when it closes
  class conflict_predictor;
    agent_t      cells[NUM_AGENTS];
    int          stored;
    bit          dropped;
    verdict_t    expected_q[$];
    int unsigned errors;

    function void take_agent(agent_t a, bit last);
      verdict_t          v;
      logic [MASK_W-1:0] mask;
      bit                hit;
      int                first_j;
      if (stored < NUM_AGENTS) begin
        cells[stored] = a;
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      mask = '0;
      for (int i = 0; i < stored; i++) begin
        hit = 1'b0;
        // vertex: another agent heads for the same cell
        for (int j = 0; j < stored; j++)
          if (j != i && cells[j].next_x == cells[i].next_x &&
              cells[j].next_y == cells[i].next_y)
            hit = 1'b1;
        // swap: only the lowest agent starting from our target counts
        first_j = -1;
        for (int j = stored - 1; j >= 0; j--)
          if (cells[j].prev_x == cells[i].next_x && cells[j].prev_y == cells[i].next_y)
            first_j = j;
        if (first_j >= 0 && first_j != i &&
            cells[i].prev_x == cells[first_j].next_x &&
            cells[i].prev_y == cells[first_j].next_y)
          hit = 1'b1;
        if (hit && i < MASK_W) mask[i] = 1'b1;
      end
      v.mask = mask;
      v.ovf  = dropped;
      expected_q = {expected_q, v};
      stored  = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(logic [MASK_W-1:0] mask, logic ovf);
      verdict_t v;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected none, actual mask %h overflow %b",
                 $time, mask, ovf);
        return;
      end
      v = expected_q.pop_front();
      if (mask !== v.mask) begin
        errors++;
        $display("%0t: conflict_mask expected %h actual %h", $time, v.mask, mask);
      end
      if (ovf !== v.ovf) begin
        errors++;
        $display("%0t: overflow expected %b actual %b", $time, v.ovf, ovf);
      end
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [FIELD_W-1:0]  prev_x_i     = '0;
  logic [FIELD_W-1:0]  prev_y_i     = '0;
  logic [FIELD_W-1:0]  next_x_i     = '0;
  logic [FIELD_W-1:0]  next_y_i     = '0;
  logic                last_agent_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [MASK_W-1:0]   conflict_mask_o;
  logic                overflow_o;

  conflict_predictor board = new();
  int send_idle_pct = 35;
  int recv_idle_pct = 71;
  int items_sent    = 0;

  agent_collision_set_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .prev_x_i       (prev_x_i),
    .prev_y_i       (prev_y_i),
    .next_x_i       (next_x_i),
    .next_y_i       (next_y_i),
    .last_agent_i   (last_agent_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .conflict_mask_o(conflict_mask_o),
    .overflow_o     (overflow_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5ms;
    $display("agent_collision_set_top: mismatch");
    $finish;
  end

  // Result side: check each transfer, then pick next cycle's ready
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        board.check_result(conflict_mask_o, overflow_o);
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One agent transfer, with random idle cycles ahead of it
  task automatic send_agent(input agent_t a, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prev_x_i     <= FIELD_W'(a.prev_x);
    prev_y_i     <= FIELD_W'(a.prev_y);
    next_x_i     <= FIELD_W'(a.next_x);
    next_y_i     <= FIELD_W'(a.next_y);
    last_agent_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_agent(a, last);
    items_sent++;
  endtask

  // Coordinate: tiny pool for dense collisions, full range, or a mix
  function automatic logic [COORD_BITS-1:0] random_coord(int style);
    if (style == 0 || (style == 2 && $urandom_range(1) == 0))
      return COORD_BITS'($urandom_range(3));
    return COORD_BITS'($urandom);
  endfunction

  // Random set, seeded with deliberate swaps and shared targets
  task automatic send_random_set();
    agent_t members[$];
    agent_t a;
    int     len;
    int     style;
    int     pick;
    int     r;
    if ($urandom_range(99) < 8)
      len = $urandom_range(NUM_AGENTS + 4, NUM_AGENTS + 1);
    else
      len = $urandom_range(NUM_AGENTS, 1);
    style = $urandom_range(2);
    for (int k = 0; k < len; k++) begin
      r        = $urandom_range(99);
      a.prev_x = random_coord(style);
      a.prev_y = random_coord(style);
      a.next_x = random_coord(style);
      a.next_y = random_coord(style);
      if (k > 0 && r < 20) begin
        pick     = $urandom_range(k - 1);
        a.prev_x = members[pick].next_x;
        a.prev_y = members[pick].next_y;
        a.next_x = members[pick].prev_x;
        a.next_y = members[pick].prev_y;
      end else if (k > 0 && r < 35) begin
        pick     = $urandom_range(k - 1);
        a.next_x = members[pick].next_x;
        a.next_y = members[pick].next_y;
      end
      members = {members, a};
      send_agent(a, k == len - 1);
    end
  endtask

  // Stimulus
  initial begin
    agent_t a;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two agents trading cells at the coordinate extremes
    send_agent('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_agent('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1);
    // Two agents heading for one cell
    send_agent('{16'h0001, 16'h0001, 16'h0005, 16'h0005}, 1'b0);
    send_agent('{16'h0002, 16'h0002, 16'h0005, 16'h0005}, 1'b1);
    // Swap seen only through the lowest agent starting at the target
    send_agent('{16'h0004, 16'h0004, 16'h0006, 16'h0006}, 1'b0);
    send_agent('{16'h0004, 16'h0004, 16'h0005, 16'h0005}, 1'b0);
    send_agent('{16'h0005, 16'h0005, 16'h0004, 16'h0004}, 1'b1);
    // Lone agent standing still
    send_agent('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1);
    // One agent too many; the dropped one would collide if it were kept
    for (int k = 0; k <= NUM_AGENTS; k++) begin
      a.prev_x = COORD_BITS'(k);
      a.prev_y = COORD_BITS'(k);
      a.next_x = COORD_BITS'(k + 100);
      a.next_y = '0;
      if (k == NUM_AGENTS - 1) a.next_x = COORD_BITS'(100);
      if (k == NUM_AGENTS)     a.next_x = COORD_BITS'(101);
      send_agent(a, k == NUM_AGENTS);
    end

    // Hold off until the block has drained
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);

    while (items_sent < 2000) begin
      if (items_sent >= 1400) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= 700) begin
        send_idle_pct = 71;
        recv_idle_pct = 35;
      end
      send_random_set();
    end

    // Drain, then allow one more compare pass for anything stray
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
    repeat (2 * NUM_AGENTS + 8) @(posedge clk_i);
    if (board.errors == 0)
      $display("agent_collision_set_top: match");
    else
      $display("agent_collision_set_top: mismatch");
    $finish;
  end

endmodule
